[rtl/odcl_pkg.sv]
// Shared types and constants for the ODoH config-list parser.
`timescale 1ns / 1ps

package odcl_pkg;

	// Field widths
	localparam int unsigned COUNT_W   = 14;
	localparam int unsigned OFFSET_W  = 17;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Frame layout constants
	localparam logic [OFFSET_W-1:0] HEADER_BYTES = 17'd4;
	localparam logic [WORD_W-1:0]   KEY_BASE     = 16'd8;

	// Result queue depth (power of two, at least 2)
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERSION    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 2'd2;

	// Configuration reset values
	localparam logic [WORD_W-1:0]  VERSION_RST  = 16'd1;
	localparam logic [COUNT_W-1:0] CAPACITY_RST = 14'd16;

	// Result kinds
	localparam logic KIND_DESC    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		PH_VLEN_HI  = 3'd0,
		PH_VLEN_LO  = 3'd1,
		PH_VER_HI   = 3'd2,
		PH_VER_LO   = 3'd3,
		PH_CLEN_HI  = 3'd4,
		PH_CLEN_LO  = 3'd5,
		PH_CONTENTS = 3'd6,
		PH_DRAIN    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_VLEN  = 3'd2,
		ST_TRUNC = 3'd3,
		ST_BAD   = 3'd4,
		ST_CAP   = 3'd5
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0]  version;
		logic [COUNT_W-1:0] capacity;
		logic               count_only;
	} cfg_t;

	typedef struct packed {
		logic                result_kind;
		logic [COUNT_W-1:0]  entry_index;
		logic [WORD_W-1:0]   entry_version;
		logic [WORD_W-1:0]   contents_length;
		logic [OFFSET_W-1:0] contents_offset;
		logic                has_key_config;
		logic [WORD_W-1:0]   kem_ident;
		logic [WORD_W-1:0]   kdf_ident;
		logic [WORD_W-1:0]   aead_ident;
		logic [WORD_W-1:0]   public_key_length;
		status_t             status;
		logic [COUNT_W-1:0]  total_entries;
	} result_t;

	// What one parsed byte can produce: a descriptor, a verdict, both or neither
	typedef struct packed {
		logic    desc_valid;
		logic    verdict_valid;
		result_t desc;
		result_t verdict;
	} step_out_t;

endpackage

[rtl/odcl_if.sv]
// Channel interfaces: frame bytes, result beats and configuration writes.
`timescale 1ns / 1ps

interface odcl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, in_byte, last, input ready);
	modport sink (input valid, in_byte, last, output ready);
endinterface

interface odcl_result_if;
	logic              valid;
	logic              ready;
	odcl_pkg::result_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface odcl_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [odcl_pkg::CFG_IDX_W-1:0]     index;
	logic [odcl_pkg::WORD_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/odcl_parse_core.sv]
// Frame parser state and per-byte step logic.
`timescale 1ns / 1ps

module odcl_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  odcl_pkg::cfg_t      cfg,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                last,
	output odcl_pkg::step_out_t res
);
	import odcl_pkg::*;

	phase_t              phase_q, phase_d;
	logic [OFFSET_W-1:0] counter_q, counter_d;
	logic [WORD_W-1:0]   vlen_q, vlen_d;
	logic [7:0]          hold_q, hold_d;
	logic [WORD_W-1:0]   ver_q, ver_d;
	logic [WORD_W-1:0]   clen_q, clen_d;
	logic [WORD_W-1:0]   seen_q, seen_d;
	logic [WORD_W-1:0]   hw_q [4];
	logic [WORD_W-1:0]   hw_d [4];
	logic [OFFSET_W-1:0] start_q, start_d;
	logic [COUNT_W-1:0]  found_q, found_d;
	status_t             err_q, err_d;

	phase_t              cur;
	logic                fin;
	logic                match;
	logic                bad;
	logic                full;
	logic [WORD_W-1:0]   pk;
	logic [OFFSET_W-1:0] key_sum;
	status_t             st;
	logic                desc_v;
	logic                verd_v;
	result_t             desc;
	result_t             verdict;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_VLEN_HI;
			counter_q <= '0;
			vlen_q    <= '0;
			hold_q    <= '0;
			ver_q     <= '0;
			clen_q    <= '0;
			seen_q    <= '0;
			hw_q      <= '{default: '0};
			start_q   <= '0;
			found_q   <= '0;
			err_q     <= ST_OK;
		end else if (step) begin
			phase_q   <= phase_d;
			counter_q <= counter_d;
			vlen_q    <= vlen_d;
			hold_q    <= hold_d;
			ver_q     <= ver_d;
			clen_q    <= clen_d;
			seen_q    <= seen_d;
			hw_q      <= hw_d;
			start_q   <= start_d;
			found_q   <= found_d;
			err_q     <= err_d;
		end
	end

	// Next state and results for one byte
	always_comb begin
		phase_d   = phase_q;
		counter_d = counter_q;
		vlen_d    = vlen_q;
		hold_d    = hold_q;
		ver_d     = ver_q;
		clen_d    = clen_q;
		seen_d    = seen_q;
		hw_d      = hw_q;
		start_d   = start_q;
		found_d   = found_q;
		err_d     = err_q;
		fin       = 1'b0;
		desc_v    = 1'b0;
		verd_v    = 1'b0;
		desc      = '0;
		verdict   = '0;
		st        = ST_OK;

		// byte past the declared vector length
		cur = phase_q;
		if (counter_q >= 17'd2 && err_q == ST_OK &&
		    (counter_q - 17'd2) >= {1'b0, vlen_q}) begin
			err_d = ST_VLEN;
			cur   = PH_DRAIN;
		end
		phase_d = cur;

		unique case (cur)
			PH_VLEN_HI: begin
				hold_d  = in_byte;
				phase_d = PH_VLEN_LO;
			end
			PH_VLEN_LO: begin
				vlen_d  = {hold_q, in_byte};
				phase_d = PH_VER_HI;
				if ({hold_q, in_byte} == '0) begin
					if (err_d == ST_OK) err_d = ST_VLEN;
					phase_d = PH_DRAIN;
				end
			end
			PH_VER_HI: begin
				start_d = counter_q;
				hold_d  = in_byte;
				phase_d = PH_VER_LO;
			end
			PH_VER_LO: begin
				ver_d   = {hold_q, in_byte};
				phase_d = PH_CLEN_HI;
			end
			PH_CLEN_HI: begin
				hold_d  = in_byte;
				phase_d = PH_CLEN_LO;
			end
			PH_CLEN_LO: begin
				clen_d = {hold_q, in_byte};
				seen_d = '0;
				hw_d   = '{default: '0};
				if ({hold_q, in_byte} == '0) begin
					fin = 1'b1;
				end else begin
					phase_d = PH_CONTENTS;
				end
			end
			PH_CONTENTS: begin
				// key config header: four big-endian words
				if (ver_q == cfg.version && seen_q < KEY_BASE) begin
					if (!seen_q[0]) begin
						hold_d = in_byte;
					end else begin
						hw_d[seen_q[2:1]] = {hold_q, in_byte};
					end
				end
				seen_d = seen_q + 16'd1;
				if (({1'b0, seen_q} + 17'd1) >= {1'b0, clen_q}) fin = 1'b1;
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase

		// Entry completion: contents check, then capacity
		match   = (ver_q == cfg.version);
		pk      = hw_d[3];
		key_sum = {1'b0, KEY_BASE} + {1'b0, pk};
		bad     = match && (clen_d < KEY_BASE || pk == '0 || {1'b0, clen_d} != key_sum);
		full    = !cfg.count_only && (found_q >= cfg.capacity);
		if (fin) begin
			if (bad) begin
				if (err_d == ST_OK) err_d = ST_BAD;
				phase_d = PH_DRAIN;
			end else if (full) begin
				if (err_d == ST_OK) err_d = ST_CAP;
				phase_d = PH_DRAIN;
			end else begin
				desc_v                 = 1'b1;
				desc.result_kind       = KIND_DESC;
				desc.entry_index       = found_q;
				desc.entry_version     = ver_q;
				desc.contents_length   = clen_d;
				desc.contents_offset   = start_q + HEADER_BYTES;
				desc.has_key_config    = match;
				desc.kem_ident         = match ? hw_d[0] : '0;
				desc.kdf_ident         = match ? hw_d[1] : '0;
				desc.aead_ident        = match ? hw_d[2] : '0;
				desc.public_key_length = match ? pk : '0;
				desc.status            = ST_OK;
				if (found_q != '1) found_d = found_q + 14'd1;
				phase_d = PH_VER_HI;
			end
		end

		// saturating byte counter
		if (counter_q != '1) counter_d = counter_q + 17'd1;

		// Frame verdict, then back to reset state
		if (last) begin
			if (counter_q == '0) begin
				st = ST_SHORT;
			end else if (vlen_d == '0 || {1'b0, vlen_d} != (counter_q - 17'd1)) begin
				st = ST_VLEN;
			end else if (err_d != ST_OK) begin
				st = err_d;
			end else if (phase_d != PH_VER_HI || found_d == '0) begin
				st = ST_TRUNC;
			end else begin
				st = ST_OK;
			end
			verd_v                = 1'b1;
			verdict.result_kind   = KIND_VERDICT;
			verdict.status        = st;
			verdict.total_entries = found_d;

			phase_d   = PH_VLEN_HI;
			counter_d = '0;
			vlen_d    = '0;
			hold_d    = '0;
			ver_d     = '0;
			clen_d    = '0;
			seen_d    = '0;
			hw_d      = '{default: '0};
			start_d   = '0;
			found_d   = '0;
			err_d     = ST_OK;
		end
	end

	assign res.desc_valid    = step && desc_v;
	assign res.verdict_valid = step && verd_v;
	assign res.desc          = desc;
	assign res.verdict       = verdict;

`ifndef SYNTHESIS
	// a recorded error always parks the parser until frame end
	a_err_drains: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_OK |-> phase_q == PH_DRAIN)
		else $error("error recorded outside drain phase");

	// a verdict returns the parser to the start of a frame
	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.verdict_valid |=> phase_q == PH_VLEN_HI && counter_q == '0 && found_q == '0)
		else $error("parser state not cleared after verdict");
`endif

endmodule

[rtl/odcl_result_fifo.sv]
// Result queue: up to two results in, one beat out per cycle when result.ready.
`timescale 1ns / 1ps

module odcl_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  odcl_pkg::step_out_t push,
	output logic                room,
	odcl_result_if.source       result
);
	import odcl_pkg::*;

	result_t           mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_q;
	logic [RES_AW-1:0] rd_q;
	logic [RES_AW:0]   count_q;
	logic [1:0]        n_push;
	logic              pop;
	result_t           first;

	// descriptor goes ahead of the verdict
	assign first  = push.desc_valid ? push.desc : push.verdict;
	assign n_push = {1'b0, push.desc_valid} + {1'b0, push.verdict_valid};
	assign pop    = result.valid && result.ready;

	// Storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) mem_q[wr_q] <= first;
		if (n_push == 2'd2) mem_q[wr_q + RES_AW'(1)] <= push.verdict;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_AW'(n_push);
			rd_q    <= rd_q + RES_AW'(pop);
			count_q <= count_q + (RES_AW + 1)'(n_push) - (RES_AW + 1)'(pop);
		end
	end

	assign room         = (count_q <= (RES_AW + 1)'(RES_DEPTH - 2));
	assign result.valid = (count_q != '0);
	assign result.data  = mem_q[rd_q];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RES_AW + 1)'(RES_DEPTH))
		else $error("result queue fill count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != 2'd0 |-> (count_q + (RES_AW + 1)'(n_push)) <= (RES_AW + 1)'(RES_DEPTH))
		else $error("result queue overflow");
`endif

endmodule

[rtl/odoh_config_list_parser_unit.sv]
// Top level of the ODoH config-list frame parser.
//
// frame  : byte channel, one frame byte per beat, last set on the final byte.
// result : result channel; an entry descriptor per completed entry, then a
//          frame verdict (status and entry count) after the last byte. A last
//          byte that also completes an entry yields the descriptor, then the
//          verdict. On a nonzero verdict the frame's descriptors are void.
// cfg    : register writes (0 decoded version, 1 entry capacity, 2 count only),
//          always ready; write only while no frame byte is in flight.
// Throughput is one byte per cycle while the queue has room. A byte is held
// in the input register and parsed from there; its results sit in a
// four-entry queue and can leave on the next cycle. The input register
// advances only while the queue has room for two results, so a stalled
// receiver backs up into frame.ready after a few beats.
// Reset clears the parser to the start of a frame, empties the queue and
// loads the register defaults (version 1, capacity 16, counting off).
`timescale 1ns / 1ps

module odoh_config_list_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	odcl_byte_if.sink     frame,
	odcl_result_if.source result,
	odcl_cfg_if.sink      cfg
);
	import odcl_pkg::*;

	cfg_t       cfg_regs_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       advance;
	step_out_t  step_res;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.version    <= VERSION_RST;
			cfg_regs_q.capacity   <= CAPACITY_RST;
			cfg_regs_q.count_only <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_VERSION:    cfg_regs_q.version    <= cfg.data;
				REG_CAPACITY:   cfg_regs_q.capacity   <= cfg.data[COUNT_W-1:0];
				REG_COUNT_ONLY: cfg_regs_q.count_only <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	assign advance     = valid_s1 && room;
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.in_byte;
			last_s1 <= frame.last;
		end
	end

	odcl_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_regs_q),
		.step    (advance),
		.in_byte (byte_s1),
		.last    (last_s1),
		.res     (step_res)
	);

	odcl_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step_res),
		.room   (room),
		.result (result)
	);

`ifndef SYNTHESIS
	// a held byte stays put while the queue lacks room for two results
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a byte while stalled");
`endif

endmodule

[sim/odoh_config_list_parser_unit_tb.sv]
// Self-checking testbench for the ODoH config-list frame parser.
`timescale 1ns / 1ps

module odoh_config_list_parser_unit_tb;
	import odcl_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int ITEMS_PER_SET = 230;
	localparam int N_ROWS       = 24;
	localparam int LONG_ENTRIES = 40;
	localparam logic [WORD_W-1:0] LONG_VLEN = 16'(LONG_ENTRIES * 4 + 3);

	// One directed byte; a typed verdict is given on some frame-final rows
	typedef struct packed {
		logic [7:0]         value;
		logic               last;
		logic               typed;
		status_t            verdict;
		logic [COUNT_W-1:0] count;
	} frame_row_t;

	logic clk;
	logic arst_n;

	odcl_byte_if   frame_ch ();
	odcl_result_if result_ch ();
	odcl_cfg_if    cfg_ch ();

	odoh_config_list_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Directed frames at the reset register values
	frame_row_t directed_rows [N_ROWS] = '{
		// too short: one byte
		'{8'hFF, 1'b1, 1'b1, ST_SHORT, 14'd0},
		// zero vector length
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b1, 1'b1, ST_VLEN,  14'd0},
		// one empty entry of version FFFF
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h04, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b1, 1'b1, ST_OK,    14'd1},
		// frame ends inside an entry header
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h03, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h02, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b1, 1'b1, ST_TRUNC, 14'd0},
		// decoded version with empty contents
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h04, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h00, 1'b1, 1'b1, ST_BAD,   14'd0},
		// bytes past the declared vector length
		'{8'h00, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'hAB, 1'b0, 1'b0, ST_OK,    14'd0},
		'{8'hCD, 1'b1, 1'b1, ST_VLEN,  14'd0}
	};

	// Parser registers as seen by the predictor
	logic [WORD_W-1:0]  cfg_version;
	logic [COUNT_W-1:0] cfg_capacity;
	logic               cfg_count_only;

	// Predictor parse state
	phase_t              cur_phase;
	logic [OFFSET_W-1:0] byte_pos;
	logic [WORD_W-1:0]   vec_len;
	logic [7:0]          hi_hold;
	logic [WORD_W-1:0]   ent_version;
	logic [WORD_W-1:0]   ent_len;
	logic [WORD_W-1:0]   ent_seen;
	logic [WORD_W-1:0]   key_words [4];
	logic [OFFSET_W-1:0] ent_start;
	logic [COUNT_W-1:0]  ent_found;
	status_t             frame_error;

	result_t    expected_results [$];
	logic [7:0] frame_bytes [$];

	int mismatch_count = 0;
	int beat_count = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit quiet = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// --------------------------------------------------------------------
	// Predictor
	// --------------------------------------------------------------------
	function automatic void clear_parser();
		cur_phase = PH_VLEN_HI;
		byte_pos = '0;
		vec_len = '0;
		hi_hold = '0;
		ent_version = '0;
		ent_len = '0;
		ent_seen = '0;
		foreach (key_words[i]) key_words[i] = '0;
		ent_start = '0;
		ent_found = '0;
		frame_error = ST_OK;
	endfunction

	function automatic void flag_error(status_t code);
		if (frame_error == ST_OK)
			frame_error = code;
		cur_phase = PH_DRAIN;
	endfunction

	// Entry complete: key config check, capacity check, then a descriptor
	function automatic void close_entry();
		result_t d;
		logic    match;
		match = (ent_version == cfg_version);
		if (match && (ent_len < KEY_BASE || key_words[3] == '0 ||
				int'(ent_len) != int'(KEY_BASE) + int'(key_words[3]))) begin
			flag_error(ST_BAD);
		end else if (!cfg_count_only && ent_found >= cfg_capacity) begin
			flag_error(ST_CAP);
		end else begin
			d = '0;
			d.result_kind = KIND_DESC;
			d.entry_index = ent_found;
			d.entry_version = ent_version;
			d.contents_length = ent_len;
			d.contents_offset = ent_start + HEADER_BYTES;
			d.has_key_config = match;
			if (match) begin
				d.kem_ident = key_words[0];
				d.kdf_ident = key_words[1];
				d.aead_ident = key_words[2];
				d.public_key_length = key_words[3];
			end
			expected_results.push_back(d);
			if (ent_found != '1)
				ent_found++;
			cur_phase = PH_VER_HI;
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic last);
		logic [OFFSET_W-1:0] p;
		result_t             v;
		p = byte_pos;
		// a byte past the declared length
		if (p >= 2 && frame_error == ST_OK && p - 2 >= {1'b0, vec_len})
			flag_error(ST_VLEN);
		case (cur_phase)
			PH_VLEN_HI: begin
				hi_hold = b;
				cur_phase = PH_VLEN_LO;
			end
			PH_VLEN_LO: begin
				vec_len = {hi_hold, b};
				cur_phase = PH_VER_HI;
				if (vec_len == '0)
					flag_error(ST_VLEN);
			end
			PH_VER_HI: begin
				ent_start = p;
				hi_hold = b;
				cur_phase = PH_VER_LO;
			end
			PH_VER_LO: begin
				ent_version = {hi_hold, b};
				cur_phase = PH_CLEN_HI;
			end
			PH_CLEN_HI: begin
				hi_hold = b;
				cur_phase = PH_CLEN_LO;
			end
			PH_CLEN_LO: begin
				ent_len = {hi_hold, b};
				ent_seen = '0;
				foreach (key_words[i]) key_words[i] = '0;
				if (ent_len == '0)
					close_entry();
				else
					cur_phase = PH_CONTENTS;
			end
			PH_CONTENTS: begin
				// first eight contents bytes of a decoded entry form four words
				if (ent_version == cfg_version && ent_seen < KEY_BASE) begin
					if (!ent_seen[0])
						hi_hold = b;
					else
						key_words[ent_seen[2:1]] = {hi_hold, b};
				end
				ent_seen++;
				if (ent_seen >= ent_len)
					close_entry();
			end
			default: ;
		endcase
		if (byte_pos != '1)
			byte_pos++;

		// frame verdict
		if (last) begin
			v = '0;
			v.result_kind = KIND_VERDICT;
			v.total_entries = ent_found;
			if (p < 1)
				v.status = ST_SHORT;
			else if (vec_len == '0 || {1'b0, vec_len} != p - 1)
				v.status = ST_VLEN;
			else if (frame_error != ST_OK)
				v.status = frame_error;
			else if (cur_phase != PH_VER_HI || ent_found == '0)
				v.status = ST_TRUNC;
			else
				v.status = ST_OK;
			expected_results.push_back(v);
			clear_parser();
		end
	endfunction

	// --------------------------------------------------------------------
	// Drivers
	// --------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 28) begin
			frame_ch.valid = 1'b0;
			@(negedge clk);
		end
		frame_ch.valid = 1'b1;
		frame_ch.in_byte = b;
		frame_ch.last = last;
		do @(posedge clk); while (!frame_ch.ready);
		parse_byte(b, last);
	endtask

	task automatic stop_offering();
		@(negedge clk);
		frame_ch.valid = 1'b0;
		frame_ch.last = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_VERSION:    cfg_version = val;
			REG_CAPACITY:   cfg_capacity = val[COUNT_W-1:0];
			REG_COUNT_ONLY: cfg_count_only = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Wait for every expected beat, then let the pipeline empty
	task automatic settle();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random frame: mostly well formed entries, some broken frames and noise
	task automatic build_frame();
		logic [7:0]        body [$];
		logic [7:0]        cont [$];
		logic [WORD_W-1:0] v;
		logic [WORD_W-1:0] pk;
		logic [WORD_W-1:0] vlen;
		int                n_ent;
		int                klen;
		int                flaw;
		int                keep;
		int                mode;
		n_ent = $urandom_range(0, 5);
		for (int e = 0; e < n_ent; e++) begin
			cont = {};
			if ($urandom_range(99) < 50) begin
				// key config for the decoded version
				v = cfg_version;
				klen = $urandom_range(1, 6);
				pk = WORD_W'(klen);
				flaw = $urandom_range(0, 19);
				repeat (6) cont.push_back(8'($urandom));
				if (flaw == 0) begin
					pk = '0;
					klen = 0;
				end else if (flaw == 3) begin
					pk = '1;
				end
				cont.push_back(pk[15:8]);
				cont.push_back(pk[7:0]);
				repeat (klen) cont.push_back(8'($urandom));
				if (flaw == 1)
					cont.push_back(8'($urandom));
				if (flaw == 2) begin
					keep = $urandom_range(0, 7);
					while (cont.size() > keep) void'(cont.pop_back());
				end
			end else begin
				v = WORD_W'($urandom);
				if (v == cfg_version)
					v = ~v;
				repeat ($urandom_range(0, 10)) cont.push_back(8'($urandom));
			end
			body.push_back(v[15:8]);
			body.push_back(v[7:0]);
			body.push_back(8'(cont.size() >> 8));
			body.push_back(8'(cont.size()));
			foreach (cont[i]) body.push_back(cont[i]);
		end

		vlen = WORD_W'(body.size());
		mode = $urandom_range(99);
		if (mode >= 80 && mode < 86) begin
			// cut inside an entry, length field follows the cut
			if (body.size() > 0) begin
				keep = $urandom_range(0, body.size() - 1);
				while (body.size() > keep) void'(body.pop_back());
			end
			vlen = WORD_W'(body.size());
		end else if (mode >= 86 && mode < 91) begin
			vlen = vlen + (($urandom_range(1) == 1) ? 16'd1 : 16'hFFFF);
		end else if (mode >= 91 && mode < 95) begin
			repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
		end

		frame_bytes = {};
		if (mode >= 98) begin
			frame_bytes.push_back(8'($urandom));
		end else if (mode >= 95) begin
			repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
		end else begin
			frame_bytes.push_back(vlen[15:8]);
			frame_bytes.push_back(vlen[7:0]);
			foreach (body[i]) frame_bytes.push_back(body[i]);
		end
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// --------------------------------------------------------------------
	// Result side: random stalls, one long hold-off on request
	// --------------------------------------------------------------------
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = quiet || ($urandom_range(99) >= 28);
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 60)
			$display("mismatch beat %0d %s: got %0h want %0h at %0t",
				beat_count, what, got, want, $time);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, kind", 32'(got.result_kind), 32'h0);
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
				check_field("entry_index", 32'(got.entry_index), 32'(want.entry_index));
				check_field("entry_version", 32'(got.entry_version), 32'(want.entry_version));
				check_field("contents_length", 32'(got.contents_length),
					32'(want.contents_length));
				check_field("contents_offset", 32'(got.contents_offset),
					32'(want.contents_offset));
				check_field("has_key_config", 32'(got.has_key_config),
					32'(want.has_key_config));
				check_field("kem_ident", 32'(got.kem_ident), 32'(want.kem_ident));
				check_field("kdf_ident", 32'(got.kdf_ident), 32'(want.kdf_ident));
				check_field("aead_ident", 32'(got.aead_ident), 32'(want.aead_ident));
				check_field("public_key_length", 32'(got.public_key_length),
					32'(want.public_key_length));
				check_field("status", 32'(got.status), 32'(want.status));
				check_field("total_entries", 32'(got.total_entries),
					32'(want.total_entries));
			end
			beat_count++;
		end
	end

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (frame_ch.valid && frame_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------
	initial begin
		result_t           typed_verdict;
		logic [WORD_W-1:0] set_ver;
		logic [WORD_W-1:0] set_cap;
		logic [WORD_W-1:0] set_co;
		logic [WORD_W-1:0] v;
		int                random_items;

		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.in_byte = '0;
		frame_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_VERSION;
		cfg_ch.data = '0;
		cfg_version = VERSION_RST;
		cfg_capacity = CAPACITY_RST;
		cfg_count_only = 1'b0;
		clear_parser();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table; typed verdicts replace the predicted ones
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].value, directed_rows[i].last);
			if (directed_rows[i].typed) begin
				typed_verdict = '0;
				typed_verdict.result_kind = KIND_VERDICT;
				typed_verdict.status = directed_rows[i].verdict;
				typed_verdict.total_entries = directed_rows[i].count;
				void'(expected_results.pop_back());
				expected_results.push_back(typed_verdict);
			end
		end
		stop_offering();
		settle();

		// Random frames under several register settings
		for (int s = 0; s < 5; s++) begin
			case (s)
				0: begin set_ver = 16'h0001; set_cap = 16'd16; set_co = 16'd0; end
				1: begin set_ver = 16'hFFFF; set_cap = 16'd0;  set_co = 16'd0; end
				2: begin set_ver = 16'h0000; set_cap = 16'd3;  set_co = 16'd0; end
				3: begin set_ver = 16'($urandom); set_cap = 16'hFFFF; set_co = 16'hFFFF; end
				default: begin set_ver = 16'hABCD; set_cap = 16'd2; set_co = 16'd1; end
			endcase
			write_reg(REG_VERSION, set_ver);
			write_reg(REG_CAPACITY, set_cap);
			write_reg(REG_COUNT_ONLY, set_co);
			quiet = (s == 3);
			if (s == 2)
				hold_request = 1'b1;
			random_items = 0;
			while (random_items < ITEMS_PER_SET) begin
				build_frame();
				send_frame();
				random_items += frame_bytes.size();
			end
			stop_offering();
			settle();
		end

		// Long frame of back-to-back entries, counting only
		quiet = 1'b1;
		write_reg(REG_VERSION, 16'h0000);
		write_reg(REG_CAPACITY, 16'h0000);
		write_reg(REG_COUNT_ONLY, 16'h0001);
		send_byte(LONG_VLEN[15:8], 1'b0);
		send_byte(LONG_VLEN[7:0], 1'b0);
		for (int e = 0; e < LONG_ENTRIES; e++) begin
			v = 16'($urandom_range(1, 65535));
			send_byte(v[15:8], 1'b0);
			send_byte(v[7:0], 1'b0);
			send_byte(8'h00, 1'b0);
			if (e < LONG_ENTRIES - 1) begin
				send_byte(8'h00, 1'b0);
			end else begin
				send_byte(8'h03, 1'b0);
				send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end
		end
		stop_offering();
		settle();
		quiet = 1'b0;

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
